### hw/rtl/bjs_pkg.sv
// Shared types, constants and helper functions for the baseline jump segmenter.
// Used by bjs_ctrl, bjs_dpath and baseline_jump_segmenter; depends on nothing.
package bjs_pkg;

  localparam int SAMPLE_BITS     = 10;
  localparam int HIST_DEPTH      = 1 << SAMPLE_BITS;
  localparam int MAX_SAMPLES_DEF = 256;
  localparam int JUMP_LIMIT      = 32;
  localparam int IDX_OUT_W       = 8;
  localparam int MRE_W           = 8;
  localparam logic [MRE_W-1:0] MRE_RESET = 8'd6;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] background;
    logic                   jump_found;
    logic [IDX_OUT_W-1:0]   jump_start;
    logic [IDX_OUT_W-1:0]   jump_end;
    logic                   final_res;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic hist_inc;
    logic sweep_issue;
    logic scan_init;
    logic walk_init;
    logic walk_step;
    logic emit_summary;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic last;
    logic walk_first;
    logic walk_end;
    logic emit_need;
    logic out_free;
  } sts_t;

  function automatic logic [SAMPLE_BITS-1:0] absdiff(input logic [SAMPLE_BITS-1:0] a,
                                                     input logic [SAMPLE_BITS-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### hw/rtl/baseline_jump_segmenter.sv
// Top level of the baseline jump segmenter: controller plus datapath.
// Depends on bjs_pkg, bjs_ctrl and bjs_dpath.
//
// Usage: sample words enter on the in_ channel, one data set at a time, the
// final sample flagged by last. Each sample word gets a histogram read, then
// an increment. Samples beyond MAX_SAMPLES are dropped.
// A word with last set starts the evaluation: a sweep over all 2**SAMPLE_BITS
// histogram entries finds the modal background and zeroes the histogram, then
// a walk goes over the stored samples. Jump words (jump_found = 1) come out
// in index order, followed by one summary word with final_res = 1.
// The out_ channel has one output register; while it holds a word that the
// receiver has not taken and a jump word is due, the walk waits. The next set
// may begin loading while the summary word still waits.
// The cfg_ channel writes min_run_excess; it is always ready. The user must
// write it only while the block is idle; the block itself does not enforce
// this.
// After reset a clearing pass zeroes the histogram, with in_ready held low;
// min_run_excess returns to 6.
module baseline_jump_segmenter #(
  parameter int MAX_SAMPLES = bjs_pkg::MAX_SAMPLES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bjs_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bjs_pkg::out_t             out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bjs_pkg::MRE_W-1:0] cfg_data
);

  bjs_pkg::cmd_t cmd;
  bjs_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bjs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bjs_dpath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // The summary word is in the output register the cycle after it is issued.
  a_summary_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_summary |=> (out_valid && out_data.final_res))
    else $error("summary word not presented after issue");

  // An accepted sample word is followed by its histogram update cycle.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready during histogram update");

  // Reset starts the histogram clearing pass, so no word is taken.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");
`endif

endmodule

### hw/rtl/bjs_ctrl.sv
// Sequencing state machine of the baseline jump segmenter.
// Depends on bjs_pkg for the command and status structs.
module bjs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bjs_pkg::sts_t sts,
  output bjs_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_TAIL,
    ST_WRD,
    ST_WEX,
    ST_SUM
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.sweep_issue = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.hist_inc = 1'b1;
        if (sts.last) begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // The mode search also zeroes each histogram entry it has read.
        cmd.sweep_issue = 1'b1;
        if (sts.sweep_last) state_nxt = ST_TAIL;
      end
      ST_TAIL: begin
        cmd.walk_init = 1'b1;
        state_nxt     = ST_WRD;
      end
      ST_WRD: begin
        state_nxt = ST_WEX;
      end
      ST_WEX: begin
        // Hold the walk while a jump word is due and the output is still full.
        if (sts.walk_first || !sts.emit_need || sts.out_free) begin
          cmd.walk_step = 1'b1;
          state_nxt     = sts.walk_end ? ST_SUM : ST_WRD;
        end
      end
      ST_SUM: begin
        if (sts.out_free) begin
          cmd.emit_summary = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/bjs_dpath.sv
// Datapath of the baseline jump segmenter: sample memory, histogram memory,
// mode search, cleaning and jump walk, output register. Depends on bjs_pkg.
module bjs_dpath #(
  parameter int MAX_SAMPLES = bjs_pkg::MAX_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bjs_pkg::in_t                   in_data,
  input  logic                           cfg_we,
  input  logic [bjs_pkg::MRE_W-1:0]      cfg_data,
  input  bjs_pkg::cmd_t                  cmd,
  output bjs_pkg::sts_t                  sts,
  input  logic                           out_ready,
  output logic                           out_valid,
  output bjs_pkg::out_t                  out_data
);

  localparam int SB     = bjs_pkg::SAMPLE_BITS;
  localparam int HD     = bjs_pkg::HIST_DEPTH;
  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int STEP_W = SB + 1;
  localparam int CMP_W  = IDX_W + bjs_pkg::MRE_W;
  localparam int K_W    = $clog2(bjs_pkg::JUMP_LIMIT + 1);
  localparam int OW     = bjs_pkg::IDX_OUT_W;
  localparam logic [STEP_W-1:0] STEP_NONE = '1;

  // Memories.
  logic [SB-1:0]    sample_mem [MAX_SAMPLES];
  logic [CNT_W-1:0] hist_mem   [HD];
  logic [SB-1:0]    smem_rdata_r;
  logic [CNT_W-1:0] hmem_rdata_r;

  // Set and configuration registers.
  logic [bjs_pkg::MRE_W-1:0] mre_r;
  logic [CNT_W-1:0]          total_r;
  logic [STEP_W-1:0]         min_step_r;
  logic [SB-1:0]             prev_r;
  logic [SB-1:0]             smp_r;
  logic                      last_r;
  logic                      stored_r;

  // Sweep and mode search.
  logic [SB-1:0]    hv_r;
  logic             cmp_valid_r;
  logic [SB-1:0]    cmp_idx_r;
  logic [CNT_W-1:0] best_r;
  logic [SB-1:0]    bg_r;

  // Walk.
  logic [IDX_W-1:0] rd_idx_r;
  logic [SB-1:0]    hold_r;
  logic             open_r;
  logic [IDX_W-1:0] start_r;
  logic [K_W-1:0]   k_r;

  logic          out_valid_r;
  bjs_pkg::out_t out_r;

  logic             full;
  logic [SB-1:0]    load_step;
  logic             step_hit;
  logic             smem_we;
  logic             h_we;
  logic [SB-1:0]    h_waddr;
  logic [SB-1:0]    h_raddr;
  logic [CNT_W-1:0] h_wdata;
  logic [SB-1:0]    dist_cur;
  logic [SB-1:0]    dist_nxt;
  logic             clean_hit;
  logic [SB-1:0]    x_clean;
  logic [IDX_W-1:0] n_idx;
  logic [IDX_W-1:0] end_idx;
  logic [IDX_W-1:0] span;
  logic             long_run;
  logic             opens;
  logic             closes;
  logic             emit_need;
  logic             out_free;
  logic             walk_first;

  assign full      = (total_r == CNT_W'(MAX_SAMPLES));
  assign load_step = bjs_pkg::absdiff(in_data.sample, prev_r);
  assign step_hit  = (total_r != '0) && (load_step != '0) && ({1'b0, load_step} < min_step_r);
  assign smem_we   = cmd.accept && !full;

  assign h_we    = cmd.sweep_issue || (cmd.hist_inc && stored_r);
  assign h_waddr = cmd.sweep_issue ? hv_r : smp_r;
  assign h_wdata = cmd.sweep_issue ? '0 : (hmem_rdata_r + CNT_W'(1));
  assign h_raddr = cmd.sweep_issue ? hv_r : in_data.sample;

  always_ff @(posedge clk) begin
    if (smem_we) sample_mem[total_r[IDX_W-1:0]] <= in_data.sample;
    smem_rdata_r <= sample_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (h_we) hist_mem[h_waddr] <= h_wdata;
    hmem_rdata_r <= hist_mem[h_raddr];
  end

  // Cleaning of sample n uses the original samples n and n+1.
  assign walk_first = (rd_idx_r == '0);
  assign dist_cur   = bjs_pkg::absdiff(bg_r, hold_r);
  assign dist_nxt   = bjs_pkg::absdiff(bg_r, smem_rdata_r);
  assign clean_hit  = (min_step_r != STEP_NONE) && ({1'b0, dist_cur} == min_step_r)
                      && ({1'b0, dist_nxt} <= min_step_r);
  assign x_clean    = clean_hit ? bg_r : hold_r;
  assign n_idx      = rd_idx_r - IDX_W'(1);
  assign end_idx    = n_idx - IDX_W'(1);
  assign span       = n_idx - start_r;
  assign long_run   = CMP_W'(span) > CMP_W'(mre_r);
  assign opens      = (x_clean > bg_r) && !open_r;
  assign closes     = (x_clean == bg_r) && open_r;
  assign emit_need  = !walk_first && closes && long_run && (k_r < K_W'(bjs_pkg::JUMP_LIMIT));
  assign out_free   = !out_valid_r || out_ready;

  assign sts.sweep_last = (hv_r == '1);
  assign sts.last       = last_r;
  assign sts.walk_first = walk_first;
  assign sts.walk_end   = (CNT_W'(rd_idx_r) + CNT_W'(1)) == total_r;
  assign sts.emit_need  = emit_need;
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mre_r       <= bjs_pkg::MRE_RESET;
      total_r     <= '0;
      min_step_r  <= STEP_NONE;
      prev_r      <= '0;
      hv_r        <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mre_r <= cfg_data;

      if (smem_we) begin
        if (step_hit) min_step_r <= {1'b0, load_step};
        prev_r  <= in_data.sample;
        total_r <= total_r + CNT_W'(1);
      end
      if (cmd.emit_summary) begin
        total_r    <= '0;
        min_step_r <= STEP_NONE;
        prev_r     <= '0;
      end

      if (cmd.sweep_issue) hv_r <= hv_r + SB'(1);
      cmp_valid_r <= cmd.sweep_issue;

      if ((cmd.walk_step && emit_need) || cmd.emit_summary) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_r    <= in_data.sample;
      last_r   <= in_data.last;
      stored_r <= !full;
    end

    cmp_idx_r <= hv_r;
    if (cmd.scan_init) begin
      best_r <= '0;
      bg_r   <= '0;
    end else if (cmp_valid_r && (hmem_rdata_r > best_r)) begin
      best_r <= hmem_rdata_r;
      bg_r   <= cmp_idx_r;
    end

    if (cmd.walk_init) begin
      rd_idx_r <= '0;
      open_r   <= 1'b0;
      k_r      <= '0;
    end else if (cmd.walk_step) begin
      hold_r   <= smem_rdata_r;
      rd_idx_r <= rd_idx_r + IDX_W'(1);
      if (!walk_first) begin
        if (opens) begin
          open_r  <= 1'b1;
          start_r <= n_idx;
        end
        if (closes) open_r <= 1'b0;
        if (emit_need) k_r <= k_r + K_W'(1);
      end
    end

    if (cmd.walk_step && emit_need) begin
      out_r.background <= bg_r;
      out_r.jump_found <= 1'b1;
      out_r.jump_start <= OW'(start_r);
      out_r.jump_end   <= OW'(end_idx);
      out_r.final_res  <= 1'b0;
    end else if (cmd.emit_summary) begin
      out_r.background <= bg_r;
      out_r.jump_found <= 1'b0;
      out_r.jump_start <= '0;
      out_r.jump_end   <= '0;
      out_r.final_res  <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
